@@ rtl/cub_pkg.sv @@
// Package for the CAN/UART frame bridge.
// Holds the framing constants and the structs passed between the bridge modules.
`default_nettype none

package cub_pkg;

  localparam logic [7:0] START_BYTE   = 8'hFD;
  localparam logic [7:0] END_BYTE     = 8'hBF;
  localparam logic [7:0] HDR_ZERO_BIT = 8'b0000_1000;
  localparam logic [7:0] HDR_ID_MASK  = 8'b0000_0111;
  localparam logic [7:0] BYTE_MASK    = 8'hFF;

  localparam logic [3:0] MAX_LEN      = 4'd8;
  localparam logic [3:0] DATA_POS     = 4'd3;

  localparam logic       KIND_UART    = 1'b0;
  localparam logic       KIND_CAN     = 1'b1;

  typedef struct packed {
    logic [10:0] id;
    logic [3:0]  len;
    logic [63:0] payload;
  } cub_frame_t;

  typedef struct packed {
    logic       busy;
    logic       last;
    logic [7:0] data;
  } cub_byte_t;

endpackage

`default_nettype wire

@@ rtl/can_uart_frame_bridge_unit.sv @@
// Top level of the CAN/UART frame bridge: deframer, framer and the output register.
// Depends on cub_pkg, cub_deframer and cub_framer.
//
//   channel   direction   handshake              payload
//   in        into block  in_valid / in_stall    action, rx_byte, in_id, in_len, in_payload
//   out       from block  out_valid / out_stall  out_kind, tx_byte, last_byte, out_id,
//                                                 out_len, out_payload
//
// Each accepted UART byte gives at most one CAN frame transfer, registered in the cycle after it.
// A CAN frame gives len + 4 output bytes (len clamped to MAX_LEN), one byte per cycle while the
// output is not stalled, from the framer's step counter; in_stall stays high until its closing byte has been loaded.
// Input is also held off while a finished transfer waits on out_stall.
// Reset returns the deframer to idle with zeroed state and empties the output register.
`default_nettype none

module can_uart_frame_bridge_unit
  import cub_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        action,
  input  wire logic [7:0]  rx_byte,
  input  wire logic [10:0] in_id,
  input  wire logic [3:0]  in_len,
  input  wire logic [63:0] in_payload,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_kind,
  output logic [7:0]       tx_byte,
  output logic             last_byte,
  output logic [10:0]      out_id,
  output logic [3:0]       out_len,
  output logic [63:0]      out_payload
);

  logic       slot_free;
  logic       accept;
  logic       fr_done;
  cub_frame_t frame;
  cub_byte_t  tx;
  logic       advance;

  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = tx.busy || !slot_free;
  assign accept    = in_valid && !in_stall;
  assign advance   = tx.busy && slot_free;

  cub_deframer u_deframer (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (accept && action == KIND_UART),
    .rx_byte    (rx_byte),
    .done       (fr_done),
    .frame      (frame)
  );

  cub_framer u_framer (
    .clk          (clk),
    .rst          (rst),
    .load         (accept && action == KIND_CAN),
    .load_id      (in_id),
    .load_len     (in_len),
    .load_payload (in_payload),
    .advance      (advance),
    .tx           (tx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (accept && action == KIND_UART && fr_done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_kind    <= KIND_UART;
      tx_byte     <= tx.data;
      last_byte   <= tx.last;
      out_id      <= 11'd0;
      out_len     <= 4'd0;
      out_payload <= 64'd0;
    end else if (accept && action == KIND_UART && fr_done) begin
      out_kind    <= KIND_CAN;
      tx_byte     <= 8'd0;
      last_byte   <= 1'b0;
      out_id      <= frame.id;
      out_len     <= frame.len;
      out_payload <= frame.payload;
    end
  end

endmodule

`default_nettype wire

@@ rtl/cub_deframer.sv @@
// Byte deframer: collects start, header, id, data and end bytes into one CAN frame.
// Depends on cub_pkg for the framing constants and the frame struct.
`default_nettype none

module cub_deframer
  import cub_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       byte_valid,
  input  wire logic [7:0] rx_byte,
  output logic            done,
  output cub_frame_t      frame
);

  logic [3:0]  pos;
  logic [3:0]  len;
  logic [10:0] id;
  logic [7:0]  data [8];

  logic [4:0]  end_pos;
  logic        in_data;
  logic        at_end;
  logic [2:0]  data_idx;

  assign end_pos  = {1'b0, DATA_POS} + {1'b0, len};
  assign in_data  = (pos >= DATA_POS) && (len <= MAX_LEN) && ({1'b0, pos} < end_pos);
  assign at_end   = (pos >= DATA_POS) && (len <= MAX_LEN) && ({1'b0, pos} == end_pos);
  assign data_idx = pos[2:0] - DATA_POS[2:0];
  assign done     = byte_valid && at_end && (rx_byte == END_BYTE);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= 4'd0;
      len <= 4'd0;
      id  <= 11'd0;
      for (int i = 0; i < 8; i++) begin
        data[i] <= 8'd0;
      end
    end else if (byte_valid) begin
      if (pos == 4'd0 && rx_byte == START_BYTE) begin
        pos <= 4'd1;
      end else if (pos == 4'd1 && (rx_byte & HDR_ZERO_BIT) == 8'd0) begin
        len <= rx_byte[7:4];
        id  <= {rx_byte[2:0], 8'd0};
        pos <= (rx_byte[7:4] <= MAX_LEN) ? 4'd2 : 4'd0;
      end else if (pos == 4'd2) begin
        id  <= {id[10:8], rx_byte};
        pos <= 4'd3;
      end else if (in_data) begin
        data[data_idx] <= rx_byte;
        pos <= pos + 4'd1;
      end else begin
        // A finished frame and every malformed byte both send the deframer back to idle.
        pos <= 4'd0;
      end
    end
  end

  // Bytes at or beyond the parsed length are zeroed, as the data array may hold stale bytes from an earlier frame.
  always_comb begin
    frame.id  = id;
    frame.len = len;
    for (int i = 0; i < 8; i++) begin
      frame.payload[8*i +: 8] = (4'(i) < len) ? data[i] : 8'd0;
    end
  end

endmodule

`default_nettype wire

@@ rtl/cub_framer.sv @@
// Byte framer: walks one CAN frame out as start, header, id, data and end bytes.
// Depends on cub_pkg for the framing constants and the byte struct.
`default_nettype none

module cub_framer
  import cub_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load,
  input  wire logic [10:0] load_id,
  input  wire logic [3:0]  load_len,
  input  wire logic [63:0] load_payload,
  input  wire logic        advance,
  output cub_byte_t        tx
);

  logic        busy;
  logic [3:0]  step;
  logic [3:0]  len;
  logic [10:0] id;
  logic [63:0] pay;
  logic        last;

  assign last = (step == (len + DATA_POS));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 4'd0;
    end else if (load) begin
      busy <= 1'b1;
      step <= 4'd0;
    end else if (advance && busy) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        step <= step + 4'd1;
      end
    end
  end

  // The data bytes leave through the low byte of a shift register.
  always_ff @(posedge clk) begin
    if (load) begin
      len <= (load_len > MAX_LEN) ? MAX_LEN : load_len;
      id  <= load_id;
      pay <= load_payload;
    end else if (advance && busy && step >= DATA_POS) begin
      pay <= {8'd0, pay[63:8]};
    end
  end

  always_comb begin
    tx.busy = busy;
    tx.last = last;
    case (step)
      4'd0:    tx.data = START_BYTE;
      4'd1:    tx.data = {len, 1'b0, id[10:8]};
      4'd2:    tx.data = id[7:0] & BYTE_MASK;
      default: tx.data = last ? END_BYTE : pay[7:0];
    endcase
  end

endmodule

`default_nettype wire
